// File: sv/abp_pkg.sv
// Package for the binomial option pricer: widths, register codes, reset values
// and the fixed-point helpers shared by the datapath and the top level.
// Depends on nothing.
`default_nettype none

package abp_pkg;

    localparam int PRICE_W       = 32;
    localparam int MAX_STEPS_DEF = 256;
    localparam int DEFAULT_STEPS = 100;
    localparam int CFG_AW        = 5;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_STRIKE   = 3'd0;
    localparam logic [2:0] REG_UP       = 3'd1;
    localparam logic [2:0] REG_DOWN     = 3'd2;
    localparam logic [2:0] REG_PROB     = 3'd3;
    localparam logic [2:0] REG_DISCOUNT = 3'd4;
    localparam logic [2:0] REG_STEPS    = 3'd5;
    localparam logic [2:0] REG_TYPE     = 3'd6;
    localparam logic [2:0] REG_INTRINS  = 3'd7;

    // Reset values of the registers
    localparam logic [31:0] RST_STRIKE   = 32'd6553600;
    localparam logic [31:0] RST_UP       = 32'd1084479660;
    localparam logic [30:0] RST_DOWN     = 31'd1063110300;
    localparam logic [30:0] RST_PROB     = 31'd536870912;
    localparam logic [31:0] RST_DISCOUNT = 32'd1073741824;
    localparam logic [8:0]  RST_STEPS    = 9'd100;

    // Coefficients the node datapath needs for one item
    typedef struct packed {
        logic [30:0]        prob_up;
        logic [30:0]        prob_down;
        logic [31:0]        discount;
        logic [PRICE_W-1:0] strike;
        logic               put;
    } abp_coef_t;

    // (a*f)>>30, saturated to the price range
    function automatic logic [PRICE_W-1:0] mul_q30(input logic [PRICE_W-1:0] a,
                                                   input logic [31:0] f);
        logic [63:0] prod;
        prod = 64'(a) * 64'(f);
        if (prod[63:62] != 2'b00)
            return '1;
        return prod[61:30];
    endfunction

    // floor(sum/2^30), saturated to the price range
    function automatic logic [PRICE_W-1:0] q30_sat(input logic [63:0] sum);
        if (sum[63:62] != 2'b00)
            return '1;
        return sum[61:30];
    endfunction

    // Call or put payoff, clamped at zero
    function automatic logic [PRICE_W-1:0] payoff(input logic [PRICE_W-1:0] s,
                                                  input logic [PRICE_W-1:0] k,
                                                  input logic put);
        if (put)
            return (k > s) ? k - s : '0;
        return (s > k) ? s - k : '0;
    endfunction

endpackage

`default_nettype wire

// File: sv/abp_stream_if.sv
// Stream channels of the option pricer: spot price in, option price out.
// Depends on abp_pkg.
`default_nettype none

interface abp_spot_if
    import abp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] spot_price;

    modport source (output valid, output spot_price, input ready);
    modport sink   (input valid, input spot_price, output ready);
endinterface

interface abp_price_if
    import abp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] option_price;

    modport source (output valid, output option_price, input ready);
    modport sink   (input valid, input option_price, output ready);
endinterface

`default_nettype wire

// File: sv/american_option_binomial_pricer.sv
// American option pricer on a Cox-Ross-Rubinstein binomial tree (top level).
// Depends on abp_pkg, abp_stream_if, abp_ram and abp_node_pipe.
//
// Usage: program the eight registers over the APB port while idle, then send
// spot prices (Q16.16) on the spot channel; each gives one option price on the
// result channel. One item is priced at a time. The node pipeline takes one
// node a cycle. The engine first runs the up-factor chain and the leaf fill.
// Every level then fetches its top price and first child and drains the node
// pipeline before the next level reads its children from the node value RAM.
// Finally the engine reads the root and loads the output register.
// With intrinsic_only set the payoff is taken at acceptance and goes straight
// to the output state; the next spot price is taken once the engine is idle.
// The spot channel is ready whenever the engine is idle, also while a finished
// price still waits in the output register; a stalled receiver holds the
// result there and the engine waits with the next price until it is taken.
// Reset returns the registers to their defaults and the engine to idle; the
// RAMs need no clearing, as every node value is written before it is read.
`default_nettype none

module american_option_binomial_pricer
    import abp_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output      logic [31:0]       prdata,
    output      logic              pready,
    abp_spot_if.sink               spot,
    abp_price_if.source            result
);

    localparam int AW = $clog2(MAX_STEPS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_UP, ST_FILL, ST_PRIME, ST_LOAD, ST_NODES,
        ST_DRAIN, ST_RES_RD, ST_RES_CAP, ST_OUT
    } state_t;

    // Configuration registers
    logic [31:0] strike_reg, up_reg, disc_reg;
    logic [30:0] down_reg, prob_reg;
    logic [8:0]  steps_reg;
    logic        type_reg, intr_reg;
    logic        cfg_we;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    // Write registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strike_reg <= RST_STRIKE;
            up_reg     <= RST_UP;
            down_reg   <= RST_DOWN;
            prob_reg   <= RST_PROB;
            disc_reg   <= RST_DISCOUNT;
            steps_reg  <= RST_STEPS;
            type_reg   <= 1'b0;
            intr_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_STRIKE:   strike_reg <= pwdata;
                REG_UP:       up_reg     <= pwdata;
                REG_DOWN:     down_reg   <= pwdata[30:0];
                REG_PROB:     prob_reg   <= pwdata[30:0];
                REG_DISCOUNT: disc_reg   <= pwdata;
                REG_STEPS:    steps_reg  <= pwdata[8:0];
                REG_TYPE:     type_reg   <= pwdata[0];
                REG_INTRINS:  intr_reg   <= pwdata[0];
                default:      ;
            endcase
        end
    end

    // Read back registers
    always_comb
    begin
        unique case (cfg_idx)
            REG_STRIKE:   prdata = strike_reg;
            REG_UP:       prdata = up_reg;
            REG_DOWN:     prdata = {1'b0, down_reg};
            REG_PROB:     prdata = {1'b0, prob_reg};
            REG_DISCOUNT: prdata = disc_reg;
            REG_STEPS:    prdata = {23'd0, steps_reg};
            REG_TYPE:     prdata = {31'd0, type_reg};
            REG_INTRINS:  prdata = {31'd0, intr_reg};
            default:      prdata = '0;
        endcase
    end

    // Derive effective step count and coefficients
    abp_coef_t     coef;
    logic [AW-1:0] n_eff;

    always_comb
    begin
        int ns;
        ns = int'(steps_reg);
        if (ns == 0)
            ns = DEFAULT_STEPS;
        if (ns > MAX_STEPS)
            ns = MAX_STEPS;
        n_eff = AW'(ns);
        coef.prob_up   = (prob_reg > ONE_Q30) ? ONE_Q30 : prob_reg;
        coef.prob_down = ONE_Q30 - coef.prob_up;
        coef.discount  = disc_reg;
        coef.strike    = strike_reg;
        coef.put       = type_reg;
    end

    // Engine state
    state_t             state_reg;
    logic [PRICE_W-1:0] x_reg, np_reg, res_reg, prev_reg;
    logic [AW-1:0]      idx_reg, lvl_reg;
    logic               out_vld_reg, rd_done_reg;
    logic [PRICE_W-1:0] out_data_reg;

    // RAM ports
    logic               nv_we, nv_re, rs_we, rs_re;
    logic [AW-1:0]      nv_waddr, nv_raddr, rs_raddr;
    logic [PRICE_W-1:0] nv_wdata, nv_rdata, rs_rdata;

    // Node pipeline ports
    logic               issue_valid;
    logic               pipe_wr_valid, pipe_busy;
    logic [AW-1:0]      pipe_wr_addr;
    logic [PRICE_W-1:0] pipe_wr_data;
    logic               fill_we;

    assign spot.ready    = (state_reg == ST_IDLE);
    assign result.valid  = out_vld_reg;
    assign result.option_price = out_data_reg;

    assign issue_valid = (state_reg == ST_NODES);
    assign fill_we     = (state_reg == ST_FILL);

    // Route RAM ports by phase
    always_comb
    begin
        nv_we    = fill_we || pipe_wr_valid;
        nv_waddr = fill_we ? idx_reg : pipe_wr_addr;
        nv_wdata = fill_we ? payoff(np_reg, strike_reg, type_reg) : pipe_wr_data;
        nv_re    = 1'b0;
        nv_raddr = '0;
        rs_re    = (state_reg == ST_PRIME);
        rs_raddr = lvl_reg;
        rs_we    = (state_reg == ST_UP);
        unique case (state_reg)
            ST_PRIME, ST_RES_RD:
            begin
                nv_re = 1'b1;
            end
            ST_NODES:
            begin
                nv_re    = 1'b1;
                nv_raddr = idx_reg + AW'(1);
            end
            default: ;
        endcase
    end

    // Sequence the tree walk and hold the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
            rd_done_reg <= 1'b0;
            idx_reg     <= '0;
            lvl_reg     <= '0;
        end
        else
        begin
            rd_done_reg <= nv_re;
            if (rd_done_reg)
            begin
                prev_reg <= nv_rdata;
            end
            if (out_vld_reg && result.ready && state_reg != ST_OUT)
            begin
                out_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (spot.valid)
                    begin
                        x_reg    <= spot.spot_price;
                        idx_reg  <= '0;
                        if (intr_reg)
                        begin
                            res_reg   <= payoff(spot.spot_price, strike_reg, type_reg);
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_UP;
                        end
                    end
                end
                ST_UP:
                begin
                    if (idx_reg == n_eff)
                    begin
                        np_reg    <= x_reg;
                        idx_reg   <= '0;
                        state_reg <= ST_FILL;
                    end
                    else
                    begin
                        x_reg   <= mul_q30(x_reg, up_reg);
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                ST_FILL:
                begin
                    np_reg <= mul_q30(np_reg, {1'b0, down_reg});
                    if (idx_reg == n_eff)
                    begin
                        lvl_reg   <= n_eff - AW'(1);
                        state_reg <= ST_PRIME;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                ST_PRIME:
                begin
                    idx_reg   <= '0;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    np_reg    <= rs_rdata;
                    state_reg <= ST_NODES;
                end
                ST_NODES:
                begin
                    np_reg <= mul_q30(np_reg, {1'b0, down_reg});
                    if (idx_reg == lvl_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!pipe_busy)
                    begin
                        if (lvl_reg == '0)
                        begin
                            state_reg <= ST_RES_RD;
                        end
                        else
                        begin
                            lvl_reg   <= lvl_reg - AW'(1);
                            state_reg <= ST_PRIME;
                        end
                    end
                end
                ST_RES_RD:
                begin
                    state_reg <= ST_RES_CAP;
                end
                ST_RES_CAP:
                begin
                    res_reg   <= nv_rdata;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_vld_reg || result.ready)
                    begin
                        out_vld_reg  <= 1'b1;
                        out_data_reg <= res_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    abp_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (MAX_STEPS + 1)
    ) u_node_ram (
        .clk   (clk),
        .we    (nv_we),
        .waddr (nv_waddr),
        .wdata (nv_wdata),
        .re    (nv_re),
        .raddr (nv_raddr),
        .rdata (nv_rdata)
    );

    abp_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (MAX_STEPS + 1)
    ) u_row_ram (
        .clk   (clk),
        .we    (rs_we),
        .waddr (idx_reg),
        .wdata (x_reg),
        .re    (rs_re),
        .raddr (rs_raddr),
        .rdata (rs_rdata)
    );

    abp_node_pipe #(
        .AW (AW)
    ) u_node_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .coef        (coef),
        .issue_valid (issue_valid),
        .issue_idx   (idx_reg),
        .issue_price (np_reg),
        .val_lo      (prev_reg),
        .val_hi      (nv_rdata),
        .wr_valid    (pipe_wr_valid),
        .wr_addr     (pipe_wr_addr),
        .wr_data     (pipe_wr_data),
        .busy        (pipe_busy)
    );

    // Leaf fill and node pipeline never share the write port
    a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(fill_we && pipe_wr_valid))
        else $error("node RAM write clash");
    // Pipeline is empty whenever a new level or the result is read
    a_read_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRIME || state_reg == ST_RES_RD) |-> !pipe_busy)
        else $error("node read before pipeline drained");
    // Node index stays within the level
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NODES) |-> (idx_reg <= lvl_reg))
        else $error("node index beyond level");
    // Engine idle means the pipeline is idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pipe_busy)
        else $error("pipeline active while idle");

endmodule

`default_nettype wire

// File: sv/abp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module abp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 257
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/abp_node_pipe.sv
// Node update pipeline: blends two child values, discounts, and keeps the
// larger of that and the early exercise value. Depends on abp_pkg.
`default_nettype none

module abp_node_pipe
    import abp_pkg::*;
#(
    parameter int AW = 9
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire abp_coef_t          coef,
    input  wire logic               issue_valid,
    input  wire logic [AW-1:0]      issue_idx,
    input  wire logic [PRICE_W-1:0] issue_price,
    input  wire logic [PRICE_W-1:0] val_lo,
    input  wire logic [PRICE_W-1:0] val_hi,
    output      logic               wr_valid,
    output      logic [AW-1:0]      wr_addr,
    output      logic [PRICE_W-1:0] wr_data,
    output      logic               busy
);

    logic [3:0] vld_reg;

    logic [AW-1:0]      idx0_reg, idx1_reg, idx2_reg, idx3_reg;
    logic [PRICE_W-1:0] price0_reg;
    logic [PRICE_W-1:0] ex1_reg, ex2_reg, ex3_reg;
    logic [62:0]        pv1_reg, qv1_reg;
    logic [PRICE_W-1:0] mix2_reg;
    logic [63:0]        cont3_reg;
    logic [PRICE_W-1:0] cont;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], issue_valid};
        end
    end

    // Payload stages: capture, weigh children, blend, discount
    always_ff @(posedge clk)
    begin
        idx0_reg   <= issue_idx;
        price0_reg <= issue_price;

        idx1_reg <= idx0_reg;
        pv1_reg  <= 63'(coef.prob_up) * 63'(val_lo);
        qv1_reg  <= 63'(coef.prob_down) * 63'(val_hi);
        ex1_reg  <= payoff(price0_reg, coef.strike, coef.put);

        idx2_reg <= idx1_reg;
        mix2_reg <= q30_sat(64'(pv1_reg) + 64'(qv1_reg));
        ex2_reg  <= ex1_reg;

        idx3_reg  <= idx2_reg;
        cont3_reg <= 64'(mix2_reg) * 64'(coef.discount);
        ex3_reg   <= ex2_reg;
    end

    // Saturate and take the larger value
    always_comb
    begin
        cont = (cont3_reg[63:62] != 2'b00) ? '1 : cont3_reg[61:30];
        wr_data = (cont > ex3_reg) ? cont : ex3_reg;
    end

    assign wr_valid = vld_reg[3];
    assign wr_addr  = idx3_reg;
    assign busy     = issue_valid || (vld_reg != '0);

    // A write always follows a matching issue through the valid stages
    a_wr_latency: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> $past(issue_valid, 4))
        else $error("node write without matching issue");
    a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> idx3_reg == $past(issue_idx, 4))
        else $error("node write address does not follow issue");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        issue_valid |=> busy)
        else $error("pipeline not busy after issue");

endmodule

`default_nettype wire

// File: tb/sv/tb_american_option_binomial_pricer.sv
// Testbench for the binomial American option pricer: programs the tree over APB,
// streams spot prices with random gaps and stalls, checks every option price.
// Depends on abp_pkg, abp_stream_if and american_option_binomial_pricer.
`default_nettype none

// Tree valuation and the queue of option prices still owed by the block
class option_price_board;
    logic [31:0] strike;
    logic [31:0] up;
    logic [30:0] down;
    logic [30:0] prob;
    logic [31:0] disc;
    logic [8:0]  steps;
    logic        put;
    logic        intr;
    logic [31:0] owed_prices[$];
    int          errors;

    function new();
        strike = abp_pkg::RST_STRIKE;
        up     = abp_pkg::RST_UP;
        down   = abp_pkg::RST_DOWN;
        prob   = abp_pkg::RST_PROB;
        disc   = abp_pkg::RST_DISCOUNT;
        steps  = abp_pkg::RST_STEPS;
        put    = 1'b0;
        intr   = 1'b0;
        errors = 0;
    endfunction

    // Mirror one register write
    function void set_reg(logic [2:0] idx, logic [31:0] value);
        case (idx)
            abp_pkg::REG_STRIKE:   strike = value;
            abp_pkg::REG_UP:       up     = value;
            abp_pkg::REG_DOWN:     down   = value[30:0];
            abp_pkg::REG_PROB:     prob   = value[30:0];
            abp_pkg::REG_DISCOUNT: disc   = value;
            abp_pkg::REG_STEPS:    steps  = value[8:0];
            abp_pkg::REG_TYPE:     put    = value[0];
            abp_pkg::REG_INTRINS:  intr   = value[0];
            default:               ;
        endcase
    endfunction

    // Shift a 64-bit product down by 30 and saturate to 32 bits
    function logic [31:0] sat_q30(logic [63:0] prod);
        logic [63:0] x;
        x = prod >> 30;
        return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    function logic [31:0] gain(logic [31:0] s, logic [31:0] k);
        if (put)
            return (k > s) ? k - s : 32'd0;
        return (s > k) ? s - k : 32'd0;
    endfunction

    function logic [31:0] row_top(logic [31:0] s, int level);
        logic [31:0] x;
        x = s;
        for (int j = 0; j < level; j++)
            x = sat_q30(64'(x) * 64'(up));
        return x;
    endfunction

    function logic [31:0] price_tree(logic [31:0] s);
        logic [31:0] vals[0:256];
        logic [31:0] px;
        logic [31:0] cont;
        logic [31:0] ex;
        logic [31:0] p;
        logic [31:0] q;
        int          n;
        if (intr)
            return gain(s, strike);
        n = steps;
        if (n == 0)
            n = abp_pkg::DEFAULT_STEPS;
        if (n > abp_pkg::MAX_STEPS_DEF)
            n = abp_pkg::MAX_STEPS_DEF;
        p = (prob > abp_pkg::ONE_Q30) ? 32'(abp_pkg::ONE_Q30) : 32'(prob);
        q = 32'(abp_pkg::ONE_Q30) - p;
        // Leaves
        px = row_top(s, n);
        for (int i = 0; i <= n; i++)
        begin
            vals[i] = gain(px, strike);
            px = sat_q30(64'(px) * 64'(down));
        end
        // Backward induction with early exercise
        for (int lv = n - 1; lv >= 0; lv--)
        begin
            px = row_top(s, lv);
            for (int i = 0; i <= lv; i++)
            begin
                cont = sat_q30(64'(vals[i]) * 64'(p) + 64'(vals[i + 1]) * 64'(q));
                cont = sat_q30(64'(cont) * 64'(disc));
                ex = gain(px, strike);
                vals[i] = (cont > ex) ? cont : ex;
                px = sat_q30(64'(px) * 64'(down));
            end
        end
        return vals[0];
    endfunction

    // Note an accepted spot price
    function void note_spot(logic [31:0] s);
        owed_prices.push_back(price_tree(s));
    endfunction

    // Check one delivered option price
    function void check_price(logic [31:0] actual);
        logic [31:0] want;
        if (owed_prices.size() == 0)
        begin
            $display("%0t: unexpected option_price %h", $time, actual);
            errors++;
            return;
        end
        want = owed_prices.pop_front();
        if (want !== actual)
        begin
            $display("%0t: option_price expected %h actual %h", $time, want, actual);
            errors++;
        end
    endfunction
endclass

module tb_american_option_binomial_pricer;
    import abp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              no_idle;
    int                cycles;

    abp_spot_if  spot ();
    abp_price_if result ();

    option_price_board board;

    american_option_binomial_pricer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .spot    (spot.sink),
        .result  (result.source)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // End the run on a hung block
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    // APB write: setup cycle, then access cycle until pready
    task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        board.set_reg(idx, value);
    endtask

    // Hold one spot transaction until accepted
    task automatic send_spot(logic [31:0] s);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            spot.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        spot.valid      <= 1'b1;
        spot.spot_price <= s;
        do
            @(posedge clk);
        while (!spot.ready);
        board.note_spot(s);
    endtask

    // Drop valid and wait until every price has come back
    task automatic drain();
        spot.valid <= 1'b0;
        while (board.owed_prices.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Receiver: stall at random, check each result transaction
    initial
    begin
        int stall;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result.valid);
            board.check_price(result.option_price);
        end
    end

    // Random but mostly sensible tree settings
    task automatic random_config();
        logic [31:0] k;
        k = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(32'h0001_0000, 32'h00C8_0000);
        cfg_write(REG_STRIKE, k);
        cfg_write(REG_UP, ($urandom_range(0, 4) == 0) ? $urandom
                          : 32'h4000_0000 + $urandom_range(0, 32'h0400_0000));
        cfg_write(REG_DOWN, ($urandom_range(0, 4) == 0) ? $urandom
                            : $urandom_range(32'h3C00_0000, 32'h4000_0000));
        cfg_write(REG_PROB, ($urandom_range(0, 4) == 0) ? $urandom
                            : $urandom_range(0, 32'h4000_0000));
        cfg_write(REG_DISCOUNT, ($urandom_range(0, 4) == 0) ? $urandom
                                : $urandom_range(32'h3F00_0000, 32'h4000_0000));
        cfg_write(REG_STEPS, $urandom_range(1, 16));
        cfg_write(REG_TYPE, $urandom_range(0, 1));
        cfg_write(REG_INTRINS, 32'($urandom_range(0, 5) == 0));
    endtask

    initial
    begin
        logic [31:0] k;
        board   = new();
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        no_idle = 1'b0;
        spot.valid      = 1'b0;
        spot.spot_price = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: at the money, zero and full-scale spot
        send_spot(32'd6553600);
        send_spot(32'd0);
        send_spot(32'hFFFF_FFFF);
        drain();

        // Intrinsic value only, call and put at the extremes
        cfg_write(REG_INTRINS, 32'd1);
        cfg_write(REG_STRIKE, 32'hFFFF_FFFF);
        send_spot(32'd0);
        send_spot(32'hFFFF_FFFF);
        drain();
        cfg_write(REG_TYPE, 32'd1);
        send_spot(32'd0);
        send_spot(32'h1234_5678);
        drain();
        cfg_write(REG_STRIKE, 32'd0);
        send_spot(32'hFFFF_FFFF);
        send_spot(32'd0);
        drain();

        // Put with zero steps (default depth) and probability above one
        cfg_write(REG_INTRINS, 32'd0);
        cfg_write(REG_STRIKE, 32'd6553600);
        cfg_write(REG_STEPS, 32'd0);
        cfg_write(REG_PROB, 32'h7FFF_FFFF);
        send_spot(32'd6000000);
        send_spot(32'd7000000);
        drain();

        // Deepest tree, factors saturating, call
        cfg_write(REG_TYPE, 32'd0);
        cfg_write(REG_STEPS, 32'd256);
        cfg_write(REG_UP, 32'hFFFF_FFFF);
        cfg_write(REG_DOWN, 32'h7FFF_FFFF);
        cfg_write(REG_DISCOUNT, 32'hFFFF_FFFF);
        cfg_write(REG_PROB, 32'd0);
        send_spot(32'h0001_0000);
        drain();

        // Step count above the maximum, unit up factor, zero down and discount
        cfg_write(REG_STEPS, 32'h0000_01FF);
        cfg_write(REG_UP, 32'h4000_0000);
        cfg_write(REG_DOWN, 32'd0);
        cfg_write(REG_DISCOUNT, 32'd0);
        cfg_write(REG_TYPE, 32'd1);
        send_spot(32'd5000000);
        drain();

        // Single step, both payoffs
        cfg_write(REG_STEPS, 32'd1);
        cfg_write(REG_UP, RST_UP);
        cfg_write(REG_DOWN, 32'(RST_DOWN));
        cfg_write(REG_DISCOUNT, RST_DISCOUNT);
        cfg_write(REG_PROB, 32'(ONE_Q30));
        send_spot(32'd6553600);
        drain();
        cfg_write(REG_TYPE, 32'd0);
        send_spot(32'd6553600);
        drain();

        // Random phases, some with no idling at all
        for (int ph = 0; ph < 8; ph++)
        begin
            random_config();
            no_idle = (ph % 3 == 2);
            k = board.strike;
            for (int i = 0; i < 12; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_spot($urandom);
                else
                    send_spot(k + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
            end
            drain();
        end

        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire
